FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files of the tank level qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that an antecedent implies a consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/tlsq_pkg.sv
// Package of the tank level qualifier: widths, tables and shared types.
package tlsq_pkg;

	localparam int TABLE_POINTS_DEF = 18;
	localparam int RAW_W = 10;
	localparam int SUP_W = 9;
	localparam int PCT_W = 7;
	localparam int APR_W = 8;
	localparam int RJ_W = 7;
	localparam int NUM_W = 42;
	localparam int DEN_W = 40;
	localparam int CNT_W = 6;

	localparam logic [APR_W-1:0] APR_RESET = 8'd16;
	localparam logic [RJ_W-1:0] RJ_RESET = 7'd10;

	// Register addresses
	localparam logic [2:0] ADDR_APR = 3'd0;
	localparam logic [2:0] ADDR_RJ = 3'd4;

	// Request to the shared serial divider.
	typedef struct packed {
		logic start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// Answer of the shared serial divider.
	typedef struct packed {
		logic done;
		logic signed [NUM_W-1:0] quo;
	} div_rsp_t;

	// First calibration table, Q6.10.
	function automatic logic signed [15:0] tab_one(input logic [4:0] i);
		logic signed [15:0] v;
		unique case (i)
			5'd0: v = 16'sd8704;
			5'd1: v = 16'sd7240;
			5'd2: v = 16'sd5253;
			5'd3: v = 16'sd3400;
			5'd4: v = 16'sd1382;
			5'd5: v = -16'sd358;
			5'd6: v = -16'sd2171;
			5'd7: v = -16'sd3809;
			5'd8: v = -16'sd5171;
			5'd9: v = -16'sd6359;
			5'd10: v = -16'sd7485;
			5'd11: v = -16'sd8397;
			5'd12: v = -16'sd9011;
			5'd13: v = -16'sd9349;
			5'd14: v = -16'sd9073;
			5'd15: v = -16'sd7956;
			5'd16: v = -16'sd4946;
			5'd17: v = -16'sd123;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	// Second calibration table, Q6.10.
	function automatic logic signed [15:0] tab_two(input logic [4:0] i);
		logic signed [15:0] v;
		unique case (i)
			5'd0: v = 16'sd12902;
			5'd1: v = 16'sd12698;
			5'd2: v = 16'sd11571;
			5'd3: v = 16'sd10138;
			5'd4: v = 16'sd8653;
			5'd5: v = 16'sd6861;
			5'd6: v = 16'sd4751;
			5'd7: v = 16'sd2540;
			5'd8: v = 16'sd307;
			5'd9: v = -16'sd1741;
			5'd10: v = -16'sd3963;
			5'd11: v = -16'sd6144;
			5'd12: v = -16'sd7987;
			5'd13: v = -16'sd9789;
			5'd14: v = -16'sd11192;
			5'd15: v = -16'sd12534;
			5'd16: v = -16'sd13568;
			5'd17: v = -16'sd12902;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	// Reliability weight of an estimate, in hundredths.
	function automatic logic [6:0] reliability(input logic signed [15:0] s);
		logic [6:0] r;
		if (s <= 18 || s > 86) r = 7'd100;
		else if (s <= 25) r = 7'd65;
		else if (s <= 32) r = 7'd50;
		else if (s <= 50) r = 7'd30;
		else if (s <= 81) r = 7'd3;
		else if (s < 85) r = 7'd15;
		else r = 7'd80;
		return r;
	endfunction

endpackage

FILE: src/tlsq_div.sv
// Bit-serial signed divider with round-half-to-even quotient.
module tlsq_div (
	input logic clk,
	input logic arst_n,
	input tlsq_pkg::div_req_t req,
	output tlsq_pkg::div_rsp_t rsp
);
	import tlsq_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [1:0] {IDLE, RUN, FIX} st_t;

	st_t st_q;
	logic [NUM_W-1:0] mag_q;     // numerator magnitude shifting out, quotient in
	logic [DEN_W:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [NUM_W-1:0] quo_q;
	logic done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] shifted;
	logic [DEN_W+1:0] rem2;
	logic signed [NUM_W:0] qfl;
	logic [NUM_W-1:0] qmag;
	logic rnz;
	logic up;

	// One restoring step per cycle on the shifted remainder.
	assign shifted = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
	assign trial = shifted - {1'b0, den_q};

	// Floor quotient for a negative numerator, then the rounding decision.
	assign qmag = mag_q;
	assign rnz = (rem_q != '0);
	always_comb begin
		logic [DEN_W:0] rr;
		rr = rem_q;
		if (neg_q && rnz) begin
			qfl = -$signed({1'b0, qmag}) - (NUM_W+1)'(1);
			rr = {1'b0, den_q} - rem_q;
		end else if (neg_q) begin
			qfl = -$signed({1'b0, qmag});
		end else begin
			qfl = $signed({1'b0, qmag});
		end
		rem2 = {rr, 1'b0};
		up = (rem2 > {2'b0, den_q}) || ((rem2 == {2'b0, den_q}) && qfl[0]);
	end

	// Sequence load, iterate and round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				IDLE: begin
					if (req.start) begin
						neg_q <= req.num[NUM_W-1];
						mag_q <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
						den_q <= req.den;
						rem_q <= '0;
						cnt_q <= CNT_W'(NUM_W - 1);
						st_q <= RUN;
					end
				end
				RUN: begin
					if (!trial[DEN_W]) begin
						rem_q <= trial;
						mag_q <= {mag_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= shifted;
						mag_q <= {mag_q[NUM_W-2:0], 1'b0};
					end
					if (cnt_q == '0) st_q <= FIX;
					else cnt_q <= cnt_q - 1'b1;
				end
				FIX: begin
					quo_q <= NUM_W'(qfl + (up ? (NUM_W+1)'(1) : (NUM_W+1)'(0)));
					done_q <= 1'b1;
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

	`ASSERT_NEXT(a_fix_done, clk, arst_n, st_q == FIX, done_q)
	`ASSERT_IMPL(a_done_idle, clk, arst_n, done_q, st_q == IDLE)
	`ASSERT_IMPL(a_run_cnt, clk, arst_n, st_q == IDLE, !done_q || cnt_q == '0)
endmodule

FILE: src/tlsq_core.sv
// Measurement sequencer: field values, table search, interpolation, blend.
module tlsq_core #(
	parameter int TABLE_POINTS = tlsq_pkg::TABLE_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [tlsq_pkg::RAW_W-1:0] a_raw,
	input logic [tlsq_pkg::RAW_W-1:0] b_raw,
	input logic [tlsq_pkg::SUP_W-1:0] sup,
	output logic done,
	output logic [tlsq_pkg::PCT_W-1:0] pct
);
	import tlsq_pkg::*;

	`include "assert_macros.svh"

	localparam int IW = $clog2(TABLE_POINTS);
	localparam logic [IW-1:0] LAST = IW'(TABLE_POINTS - 1);
	localparam logic [IW-1:0] KMAX = IW'(TABLE_POINTS - 2);

	// Estimate paths and interpolation selects.
	localparam logic [1:0] MODE_NORM = 2'd0;
	localparam logic [1:0] MODE_NEAR = 2'd2;
	localparam logic [1:0] SEL_K1 = 2'd0;
	localparam logic [1:0] SEL_K2 = 2'd1;
	localparam logic [1:0] SEL_K3 = 2'd2;

	typedef enum logic [3:0] {
		IDLE, F1, F2, SCAN, PICK, I1, I2, I3, RES, BL, OUT
	} st_t;

	st_t st_q;
	st_t prev_st_q;
	div_req_t req;
	div_rsp_t rsp;
	logic signed [15:0] f1_q, f2_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] k1_q, k2_q, k3_q;
	logic k1n_q, k1f_q, k3f_q;
	logic [IW-1:0] best_q;
	logic [16:0] bd_q;
	logic signed [15:0] d0_q, d1_q, alt_q;
	logic [1:0] mode_q;
	logic [1:0] isel_q;
	logic [PCT_W-1:0] pct_q;
	logic done_q;
	logic [SUP_W-1:0] sup_q;
	logic [RAW_W-1:0] b_q;

	tlsq_div u_div (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// Table reads at the scan index.
	logic signed [15:0] t1i, t2i, ta, tb;
	logic [16:0] pt_dist;
	logic [IW-1:0] ksel;
	logic ktab;
	assign t1i = tab_one(5'(i_q));
	assign t2i = tab_two(5'(i_q));
	assign pt_dist = ($signed({t1i[15], t1i}) - $signed({f1_q[15], f1_q})) < 0 ?
		17'($signed({f1_q[15], f1_q}) - $signed({t1i[15], t1i})) :
		17'($signed({t1i[15], t1i}) - $signed({f1_q[15], f1_q}));

	// Segment and table for the current interpolation.
	always_comb begin
		unique case (isel_q)
			SEL_K1: begin ksel = k1_q; ktab = 1'b0; end
			SEL_K2: begin ksel = k2_q; ktab = 1'b0; end
			default: begin ksel = k3_q; ktab = 1'b1; end
		endcase
		ta = ktab ? tab_two(5'(ksel)) : tab_one(5'(ksel));
		tb = ktab ? tab_two(5'(ksel + 1'b1)) : tab_one(5'(ksel + 1'b1));
	end

	// Interpolation numerator and denominator.
	logic signed [NUM_W-1:0] inum;
	logic signed [17:0] seg;
	logic signed [NUM_W-1:0] iden_s;
	logic signed [15:0] fsel;
	logic signed [7:0] base;
	logic signed [25:0] bprod;
	logic signed [19:0] fdiff;
	assign fsel = ktab ? f2_q : f1_q;
	assign seg = 18'(tb) - 18'(ta);
	assign base = 8'(10 + 5 * int'(ksel));
	assign bprod = 26'(base) * 26'(seg);
	assign fdiff = 20'(fsel) - 20'(ta);
	always_comb begin
		inum = NUM_W'(bprod) + NUM_W'(fdiff) * NUM_W'(5);
		iden_s = NUM_W'(seg);
		if (seg < 0) begin
			inum = -inum;
			iden_s = -iden_s;
		end
	end

	// Field numerator and denominator for one reading.
	logic [RAW_W-1:0] rsel;
	logic signed [NUM_W-1:0] fnum;
	logic [DEN_W-1:0] fden;
	assign rsel = (st_q == IDLE) ? a_raw : b_q;
	assign fnum = NUM_W'(64'sd1048064000 * $signed({1'b0, rsel}))
		- NUM_W'(64'sd2144335872 * $signed({1'b0, (st_q == IDLE) ? sup : sup_q}));
	assign fden = DEN_W'(102300) * DEN_W'((st_q == IDLE) ? sup : sup_q);

	logic signed [15:0] fsat;
	assign fsat = (rsp.quo > 32767) ? 16'sd32767 :
		(rsp.quo < -32768) ? -16'sd32768 : 16'(rsp.quo);

	// Correction of the ambiguous estimate.
	logic signed [16:0] ad1, ad0, dalt;
	assign ad1 = (alt_q - d1_q) < 0 ? 17'(d1_q - alt_q) : 17'(alt_q - d1_q);
	assign ad0 = (d1_q - d0_q) < 0 ? 17'(d0_q - d1_q) : 17'(d1_q - d0_q);
	assign dalt = 17'(alt_q) - ad1 + 17'sd5;

	// Blend weights and weighted sum.
	logic [6:0] w1, w2;
	logic signed [23:0] bp0, bp1;
	assign w1 = reliability(d0_q);
	assign w2 = 7'd100 - reliability(d1_q);
	assign bp0 = 24'($signed({1'b0, w1})) * 24'(d0_q);
	assign bp1 = 24'($signed({1'b0, w2})) * 24'(d1_q);

	logic signed [NUM_W-1:0] quo;
	assign quo = rsp.quo;

	// Divider starts for each field and on entry to I1-I3 and BL.
	always_comb begin
		req.start = 1'b0;
		req.num = fnum;
		req.den = fden;
		unique case (st_q)
			IDLE: req.start = start;
			F1: req.start = rsp.done;
			I1, I2, I3: begin
				req.start = (prev_st_q != st_q);
				req.num = inum;
				req.den = DEN_W'(iden_s);
			end
			BL: begin
				req.start = (prev_st_q != st_q);
				req.num = NUM_W'(bp0) + NUM_W'(bp1);
				req.den = DEN_W'(w1) + DEN_W'(w2);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done_q <= 1'b0;
			isel_q <= '0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				// Start the first field division.
				IDLE: begin
					if (start) begin
						sup_q <= sup;
						b_q <= b_raw;
						st_q <= F1;
					end
				end
				// Hold f1, start the second field.
				F1: begin
					if (rsp.done) begin
						f1_q <= fsat;
						st_q <= F2;
					end
				end
				F2: begin
					if (rsp.done) begin
						f2_q <= fsat;
						i_q <= '0;
						k1f_q <= 1'b0; k3f_q <= 1'b0;
						k1_q <= '0; k1n_q <= 1'b0; k2_q <= LAST; k3_q <= '0;
						best_q <= '0;
						bd_q <= '1;
						st_q <= SCAN;
					end
				end
				// Walk both tables one point a cycle.
				SCAN: begin
					if (t1i < f1_q) begin
						k2_q <= i_q;
						if (!k1f_q) begin
							k1f_q <= 1'b1;
							if (i_q == '0) k1n_q <= 1'b1;
							else k1_q <= i_q - 1'b1;
						end
					end
					if (t2i < f2_q && !k3f_q) begin
						k3f_q <= 1'b1;
						k3_q <= (i_q == '0) ? '0 : i_q - 1'b1;
					end
					if (pt_dist < bd_q) begin
						bd_q <= pt_dist;
						best_q <= i_q;
					end
					if (i_q == LAST) st_q <= PICK;
					else i_q <= i_q + 1'b1;
				end
				// Decide the case; clamp segments.
				PICK: begin
					if (k2_q > KMAX) k2_q <= KMAX;
					if (k1n_q && k2_q == LAST && f2_q > 0) begin
						d0_q <= 16'sd10;
						d1_q <= 16'sd10;
						st_q <= BL;
					end else if (!k1n_q && k1_q == '0 && k2_q == LAST && f2_q < 0) begin
						d0_q <= 16'(10 + 5 * int'(best_q));
						mode_q <= MODE_NEAR;
						if (k3_q == '0) begin
							d1_q <= 16'sd90;
							st_q <= BL;
						end else begin
							isel_q <= SEL_K3;
							st_q <= I3;
						end
					end else begin
						mode_q <= MODE_NORM;
						isel_q <= SEL_K1;
						st_q <= I1;
					end
				end
				I1: begin
					if (rsp.done) begin
						d0_q <= 16'(quo);
						isel_q <= SEL_K2;
						st_q <= I2;
					end
				end
				I2: begin
					if (rsp.done) begin
						alt_q <= 16'(quo);
						if (k3_q == '0 && f2_q < 0) begin
							d1_q <= 16'sd90;
							st_q <= RES;
						end else begin
							isel_q <= SEL_K3;
							st_q <= I3;
						end
					end
				end
				I3: begin
					if (rsp.done) begin
						d1_q <= 16'(quo);
						st_q <= (mode_q == MODE_NEAR) ? BL : RES;
					end
				end
				RES: begin
					if (ad1 < ad0) begin
						if (d1_q <= 80 && ad1 > 5) d0_q <= 16'(dalt);
						else d0_q <= alt_q;
					end
					st_q <= BL;
				end
				BL: begin
					if (rsp.done) begin
						pct_q <= (quo < 0) ? '0 : (quo > 100) ? 7'd100 : PCT_W'(quo);
						done_q <= 1'b1;
						st_q <= IDLE;
					end
				end
				default: st_q <= IDLE;
			endcase
			// Clamped below-zero index for the first search.
			if (st_q == PICK && k1n_q) k1_q <= '0;
		end
	end

	// Track the previous state to spot state entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prev_st_q <= IDLE;
		else prev_st_q <= st_q;
	end

	assign done = done_q;
	assign pct = pct_q;

	`ASSERT_IMPL(a_done_range, clk, arst_n, done_q, pct_q <= 7'd100)
	`ASSERT_NEXT(a_start_leaves, clk, arst_n, st_q == IDLE && start, st_q == F1)
	`ASSERT_IMPL(a_scan_idx, clk, arst_n, st_q == SCAN, i_q <= LAST)
endmodule

FILE: src/tank_level_sensor_qualifier_top.sv
// Top level of the tank level qualifier: handshake, registers, report logic.
//
// One sample is taken at a time. A disconnected sample bypasses the core: its
// disconnect flag is registered on acceptance, then its result is loaded into
// the output register. A connected one is sequenced through the shared
// bit-serial divider (up to six divisions: two field values, three
// interpolations, one blend) and a scan of both tables. The result waits in an
// output register and the next sample is taken once it has been delivered.
module tank_level_sensor_qualifier_top #(
	parameter int TABLE_POINTS = tlsq_pkg::TABLE_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [tlsq_pkg::RAW_W-1:0] gas_a_raw,
	input logic [tlsq_pkg::RAW_W-1:0] gas_b_raw,
	input logic [tlsq_pkg::SUP_W-1:0] supply_level,
	output logic out_valid,
	input logic out_stall,
	output logic [tlsq_pkg::PCT_W-1:0] tank_percent,
	output logic transmit,
	output logic disconnected,
	output logic recheck_soon
);
	import tlsq_pkg::*;

	`include "assert_macros.svh"

	logic [APR_W-1:0] apr_q;
	logic [RJ_W-1:0] rj_q;
	logic busy_q;
	logic disc_q;
	logic [PCT_W-1:0] prev_q;
	logic [APR_W-1:0] cnt_q;
	logic idle_q;
	logic ov_q;
	logic [PCT_W-1:0] pct_q;
	logic tx_q, dc_q, rc_q;

	logic acc;
	logic core_done;
	logic [PCT_W-1:0] core_pct;
	logic disc_now;
	logic [11:0] volt;
	logic [RAW_W:0] dab;
	logic [12:0] dvb;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_RJ) ? {25'b0, rj_q} :
		(paddr == ADDR_APR) ? {24'b0, apr_q} : 32'b0;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apr_q <= APR_RESET;
			rj_q <= RJ_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_APR) apr_q <= pwdata[APR_W-1:0];
			else if (paddr == ADDR_RJ) rj_q <= pwdata[RJ_W-1:0];
		end
	end

	// Disconnect test: floor(2.046 * supply) by constant multiply and shift.
	assign volt = 12'((41'(supply_level) * 41'd2196876132) >> 30);
	assign dab = (gas_b_raw > gas_a_raw) ? 11'(gas_b_raw - gas_a_raw) :
		11'(gas_a_raw - gas_b_raw);
	assign dvb = (13'(volt) > 13'(gas_b_raw)) ? 13'(volt) - 13'(gas_b_raw) :
		13'(gas_b_raw) - 13'(volt);
	assign disc_now = (supply_level == '0) || (dab <= 11'd7 && dvb < 13'd35);

	assign in_stall = busy_q;
	assign acc = in_valid && !busy_q;

	tlsq_core #(.TABLE_POINTS(TABLE_POINTS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(acc && !disc_now),
		.a_raw(gas_a_raw), .b_raw(gas_b_raw), .sup(supply_level),
		.done(core_done), .pct(core_pct)
	);

	// Final percentage and report decision.
	logic fin;
	logic [PCT_W-1:0] p;
	logic due, tx;
	logic signed [PCT_W+1:0] rise;
	assign fin = (busy_q && !ov_q) && (disc_q || core_done);
	assign p = disc_q ? '0 : core_pct;
	assign due = !idle_q && (cnt_q == apr_q - 1'b1);
	assign rise = $signed({2'b0, p}) - $signed({2'b0, prev_q});
	always_comb begin
		if (p == '0) tx = (prev_q != '0);
		else tx = (prev_q == '0) || (rise >= $signed({2'b0, rj_q})) || due;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			disc_q <= 1'b0;
			ov_q <= 1'b0;
			prev_q <= '0;
			cnt_q <= '0;
			idle_q <= 1'b1;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
				disc_q <= disc_now;
			end
			if (fin) begin
				ov_q <= 1'b1;
				pct_q <= p;
				tx_q <= tx;
				dc_q <= disc_q;
				rc_q <= (p == '0);
				prev_q <= p;
				if (p == '0) begin
					idle_q <= 1'b1;
					cnt_q <= '0;
				end else if (due || idle_q) begin
					idle_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign tank_percent = pct_q;
	assign transmit = tx_q;
	assign disconnected = dc_q;
	assign recheck_soon = rc_q;

	`ASSERT_IMPL(a_ov_busy, clk, arst_n, ov_q, busy_q)
	`ASSERT_IMPL(a_disc_zero, clk, arst_n, ov_q && dc_q, pct_q == '0 && rc_q)
	`ASSERT_NEXT(a_fin_out, clk, arst_n, fin, ov_q)
endmodule
